// File: src/command_call_syntax_scanner_top_defines.svh
// Assertion macros used by the scanner top level
`ifndef COMMAND_CALL_SYNTAX_SCANNER_TOP_DEFINES_SVH
`define COMMAND_CALL_SYNTAX_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CCSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ccss_pkg.sv
// Types, codes and character classes of the command call syntax scanner
`default_nettype none

package ccss_pkg;

    typedef enum logic [2:0]
    {
        PH_LEAD  = 3'd0,
        PH_NAME  = 3'd1,
        PH_GAP   = 3'd2,
        PH_LIST  = 3'd3,
        PH_TRAIL = 3'd4
    } phase_t;

    localparam logic [2:0] ROLE_SPACE   = 3'd0;
    localparam logic [2:0] ROLE_NAME    = 3'd1;
    localparam logic [2:0] ROLE_OPEN    = 3'd2;
    localparam logic [2:0] ROLE_ARG     = 3'd3;
    localparam logic [2:0] ROLE_COMMA   = 3'd4;
    localparam logic [2:0] ROLE_CLOSE   = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    localparam logic [3:0] STAT_OK         = 4'd0;
    localparam logic [3:0] STAT_BAD_NAME   = 4'd1;
    localparam logic [3:0] STAT_OPEN_SQ    = 4'd2;
    localparam logic [3:0] STAT_OPEN_DQ    = 4'd3;
    localparam logic [3:0] STAT_UNMATCHED  = 4'd4;
    localparam logic [3:0] STAT_DANGLE_ESC = 4'd5;
    localparam logic [3:0] STAT_UNCLOSED   = 4'd6;
    localparam logic [3:0] STAT_JUNK       = 4'd7;
    localparam logic [3:0] STAT_TOO_MANY   = 4'd8;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    typedef struct packed
    {
        phase_t     phase;
        logic       sq;
        logic       dq;
        logic       esc;
        logic [3:0] err;
    } scan_state_t;

    typedef struct packed
    {
        logic [2:0] role;
        logic [3:0] arg_number;
        logic       end_of_command;
        logic [3:0] status;
    } scan_result_t;

    localparam scan_state_t SCAN_RESET = '{phase: PH_LEAD, sq: 1'b0, dq: 1'b0,
                                           esc: 1'b0, err: STAT_OK};

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
               c == 8'h0A || c == 8'h0D || c == 8'h00;
    endfunction

    function automatic logic is_alpha_us(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha_us(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// File: src/ccss_step.sv
// Next-state and result logic for one byte of the command line
`default_nettype none

module ccss_step #(
    parameter int MAX_NEST = 255,
    parameter int MAX_ARGS = 16,
    parameter int NEST_W   = 8,
    parameter int ARG_W    = 4
) (
    input  var ccss_pkg::scan_state_t  state_cur,
    input  var logic [NEST_W-1:0]      nest_cur,
    input  var logic [ARG_W-1:0]       arg_cur,
    input  var logic [7:0]             c,
    input  var logic                   last_in,
    output ccss_pkg::scan_state_t      state_next,
    output logic [NEST_W-1:0]          nest_next,
    output logic [ARG_W-1:0]           arg_next,
    output ccss_pkg::scan_result_t     result
);

    ccss_pkg::scan_state_t st;
    logic [NEST_W-1:0]     nest;
    logic [ARG_W-1:0]      argc;
    logic [ARG_W-1:0]      argn;
    logic [2:0]            role;
    logic [3:0]            status;
    logic                  quoted;
    logic                  clr_esc;

    always_comb
    begin
        st      = state_cur;
        nest    = nest_cur;
        argc    = arg_cur;
        argn    = '0;
        role    = ccss_pkg::ROLE_IGNORED;
        status  = ccss_pkg::STAT_OK;
        quoted  = state_cur.sq | state_cur.dq;
        clr_esc = 1'b1;

        if (state_cur.err == ccss_pkg::STAT_OK)
        begin
            unique case (state_cur.phase)
                ccss_pkg::PH_LEAD:
                begin
                    if (ccss_pkg::is_space(c))
                        role = ccss_pkg::ROLE_SPACE;
                    else if (ccss_pkg::is_alpha_us(c))
                    begin
                        st.phase = ccss_pkg::PH_NAME;
                        role     = ccss_pkg::ROLE_NAME;
                    end
                    else
                        st.err = ccss_pkg::STAT_BAD_NAME;
                end
                ccss_pkg::PH_NAME:
                begin
                    if (ccss_pkg::is_ident(c))
                        role = ccss_pkg::ROLE_NAME;
                    else if (ccss_pkg::is_space(c))
                    begin
                        st.phase = ccss_pkg::PH_GAP;
                        role     = ccss_pkg::ROLE_SPACE;
                    end
                    else if (c == ccss_pkg::CH_LPAREN)
                    begin
                        st.phase = ccss_pkg::PH_LIST;
                        role     = ccss_pkg::ROLE_OPEN;
                    end
                    else
                        st.err = ccss_pkg::STAT_JUNK;
                end
                ccss_pkg::PH_GAP:
                begin
                    if (ccss_pkg::is_space(c))
                        role = ccss_pkg::ROLE_SPACE;
                    else if (c == ccss_pkg::CH_LPAREN)
                    begin
                        st.phase = ccss_pkg::PH_LIST;
                        role     = ccss_pkg::ROLE_OPEN;
                    end
                    else
                        st.err = ccss_pkg::STAT_JUNK;
                end
                ccss_pkg::PH_LIST:
                begin
                    argn = arg_cur;
                    role = ccss_pkg::ROLE_ARG;
                    if (c == ccss_pkg::CH_BSLASH && !state_cur.esc && quoted)
                    begin
                        st.esc  = 1'b1;
                        clr_esc = 1'b0;
                    end
                    else if (c == ccss_pkg::CH_SQUOTE)
                    begin
                        if (!state_cur.dq && (!state_cur.sq || !state_cur.esc))
                            st.sq = ~state_cur.sq;
                    end
                    else if (c == ccss_pkg::CH_DQUOTE)
                    begin
                        if (!state_cur.sq && (!state_cur.dq || !state_cur.esc))
                            st.dq = ~state_cur.dq;
                    end
                    else if (c == ccss_pkg::CH_LPAREN && !quoted)
                    begin
                        if (nest_cur == NEST_W'(MAX_NEST))
                        begin
                            st.err  = ccss_pkg::STAT_UNMATCHED;
                            role    = ccss_pkg::ROLE_IGNORED;
                            argn    = '0;
                            clr_esc = 1'b0;
                        end
                        else
                            nest = nest_cur + NEST_W'(1);
                    end
                    else if (c == ccss_pkg::CH_COMMA && !quoted && nest_cur == '0)
                    begin
                        clr_esc = 1'b0;
                        if (arg_cur == ARG_W'(MAX_ARGS - 1))
                        begin
                            st.err = ccss_pkg::STAT_TOO_MANY;
                            role   = ccss_pkg::ROLE_IGNORED;
                            argn   = '0;
                        end
                        else
                        begin
                            argc = arg_cur + ARG_W'(1);
                            role = ccss_pkg::ROLE_COMMA;
                        end
                    end
                    else if (c == ccss_pkg::CH_RPAREN && !quoted)
                    begin
                        if (nest_cur != '0)
                            nest = nest_cur - NEST_W'(1);
                        else
                        begin
                            st.phase = ccss_pkg::PH_TRAIL;
                            role     = ccss_pkg::ROLE_CLOSE;
                            clr_esc  = 1'b0;
                        end
                    end
                    if (clr_esc)
                        st.esc = 1'b0;
                end
                default:
                begin
                    if (ccss_pkg::is_space(c))
                        role = ccss_pkg::ROLE_SPACE;
                    else
                        st.err = ccss_pkg::STAT_JUNK;
                end
            endcase
        end

        if (last_in)
        begin
            if (st.err != ccss_pkg::STAT_OK)
                status = st.err;
            else if (st.phase == ccss_pkg::PH_LEAD)
                status = ccss_pkg::STAT_BAD_NAME;
            else if (st.phase == ccss_pkg::PH_LIST)
            begin
                priority if (st.sq)
                    status = ccss_pkg::STAT_OPEN_SQ;
                else if (st.dq)
                    status = ccss_pkg::STAT_OPEN_DQ;
                else if (nest != '0)
                    status = ccss_pkg::STAT_UNMATCHED;
                else if (st.esc)
                    status = ccss_pkg::STAT_DANGLE_ESC;
                else
                    status = ccss_pkg::STAT_UNCLOSED;
            end
        end

        result.role           = role;
        result.arg_number     = 4'(argn);
        result.end_of_command = last_in;
        result.status         = status;

        if (last_in)
        begin
            state_next = ccss_pkg::SCAN_RESET;
            nest_next  = '0;
            arg_next   = '0;
        end
        else
        begin
            state_next = st;
            nest_next  = nest;
            arg_next   = argc;
        end
    end

endmodule

`default_nettype wire

// File: src/command_call_syntax_scanner_top.sv
// Top level of the command call syntax scanner
//
// Scans a command line of the form name(arg,arg) one byte per word and tags
// each byte with its role, the argument it belongs to, and on the word marked
// last a status code, after which the scanner is back in its reset state.
// A byte is taken into an input register; its scan state update and result are
// computed combinationally and land in an output register. One word per cycle is
// sustained while out_ready stays high; the scan state registers (state, nest
// level, argument count), updated once per byte, set that rate. in_ready drops
// only while both registers hold words that the output side has not taken. No
// clearing pass after reset.
`default_nettype none
`include "command_call_syntax_scanner_top_defines.svh"

module command_call_syntax_scanner_top #(
    parameter int MAX_NEST = 255,
    parameter int MAX_ARGS = 16
) (
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       in_valid,
    output logic           in_ready,
    input  var logic [7:0] in_byte,
    input  var logic       last,
    output logic           out_valid,
    input  var logic       out_ready,
    output logic [2:0]     role,
    output logic [3:0]     arg_number,
    output logic           end_of_command,
    output logic [3:0]     status
);

    localparam int NEST_W = ($clog2(MAX_NEST + 1) > 0) ? $clog2(MAX_NEST + 1) : 1;
    localparam int ARG_W  = ($clog2(MAX_ARGS) > 0) ? $clog2(MAX_ARGS) : 1;

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic                   out_valid_reg;
    ccss_pkg::scan_result_t result_reg;
    ccss_pkg::scan_result_t result_next;
    ccss_pkg::scan_state_t  state_reg;
    ccss_pkg::scan_state_t  state_next;
    logic [NEST_W-1:0]      nest_reg;
    logic [NEST_W-1:0]      nest_next;
    logic [ARG_W-1:0]       arg_reg;
    logic [ARG_W-1:0]       arg_next;
    logic                   advance;
    logic                   in_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    ccss_step #(
        .MAX_NEST (MAX_NEST),
        .MAX_ARGS (MAX_ARGS),
        .NEST_W   (NEST_W),
        .ARG_W    (ARG_W)
    ) u_step (
        .state_cur  (state_reg),
        .nest_cur   (nest_reg),
        .arg_cur    (arg_reg),
        .c          (byte_reg),
        .last_in    (last_reg),
        .state_next (state_next),
        .nest_next  (nest_next),
        .arg_next   (arg_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ccss_pkg::SCAN_RESET;
            nest_reg      <= '0;
            arg_reg       <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                nest_reg      <= nest_next;
                arg_reg       <= arg_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= in_byte;
            last_reg <= last;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign role           = result_reg.role;
    assign arg_number     = result_reg.arg_number;
    assign end_of_command = result_reg.end_of_command;
    assign status         = result_reg.status;

    `CCSS_ASSERT_NOW(a_status_only_at_end,
        out_valid_reg && result_reg.status != ccss_pkg::STAT_OK,
        result_reg.end_of_command, "status set on a word that is not last")
    `CCSS_ASSERT_NOW(a_ignored_has_no_arg,
        out_valid_reg && result_reg.role == ccss_pkg::ROLE_IGNORED,
        result_reg.arg_number == 4'd0, "ignored byte carries an argument index")
    `CCSS_ASSERT_NEXT(a_reset_after_last,
        advance && last_reg,
        state_reg == ccss_pkg::SCAN_RESET && nest_reg == '0 && arg_reg == '0,
        "scan state not cleared after last byte")
    `CCSS_ASSERT_NEXT(a_error_sticky,
        state_reg.err != ccss_pkg::STAT_OK && !(advance && last_reg),
        state_reg.err == $past(state_reg.err), "sticky error changed inside a line")
    `CCSS_ASSERT_NOW(a_nest_bounded,
        1'b1, {1'b0, nest_reg} <= (NEST_W + 1)'(MAX_NEST), "nest level above limit")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the command call syntax scanner: queued byte driver, tag monitor, own predictor
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_NEST    = 255;
    localparam int MAX_ARGS    = 16;
    localparam int DIRECTED    = 24;
    localparam int RAND_WORDS  = 550;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 40;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       fin;
    } word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] role;
    logic [3:0] arg_number;
    logic       end_of_command;
    logic [3:0] status;

    word_t                  pending_words[$];
    ccss_pkg::scan_result_t expected_tags[$];
    logic [7:0]             line_buf[$];

    ccss_pkg::phase_t sc_phase;
    logic             sc_sq;
    logic             sc_dq;
    logic             sc_esc;
    int unsigned      sc_nest;
    int unsigned      sc_args;
    logic [3:0]       sc_err;

    int unsigned cyc           = 0;
    int unsigned stall_cycles  = 0;
    int unsigned err_count     = 0;
    int unsigned tags_checked  = 0;
    int unsigned lines_checked = 0;
    logic [15:0] status_seen   = '0;
    logic        calm;

    assign calm = cyc >= 150 && cyc < 450;

    command_call_syntax_scanner_top #(
        .MAX_NEST(MAX_NEST),
        .MAX_ARGS(MAX_ARGS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .role(role),
        .arg_number(arg_number),
        .end_of_command(end_of_command),
        .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic is_blank_byte(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C ||
               c == 8'h0A || c == 8'h0D || c == 8'h00;
    endfunction

    function automatic logic is_name_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_name_body(input logic [7:0] c);
        return is_name_head(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic void scan_clear();
        sc_phase = ccss_pkg::PH_LEAD;
        sc_sq    = 1'b0;
        sc_dq    = 1'b0;
        sc_esc   = 1'b0;
        sc_nest  = 0;
        sc_args  = 0;
        sc_err   = ccss_pkg::STAT_OK;
    endfunction

    function automatic ccss_pkg::scan_result_t scan_byte(input logic [7:0] c, input logic fin);
        ccss_pkg::scan_result_t r;
        logic                   quoted;
        logic                   clr_esc;
        r = '{role: ccss_pkg::ROLE_IGNORED, arg_number: 4'd0, end_of_command: fin,
              status: ccss_pkg::STAT_OK};
        quoted  = sc_sq | sc_dq;
        clr_esc = 1'b1;
        if (sc_err == ccss_pkg::STAT_OK)
        begin
            case (sc_phase)
                ccss_pkg::PH_LEAD:
                    if (is_blank_byte(c))
                        r.role = ccss_pkg::ROLE_SPACE;
                    else if (is_name_head(c))
                    begin
                        sc_phase = ccss_pkg::PH_NAME;
                        r.role   = ccss_pkg::ROLE_NAME;
                    end
                    else
                        sc_err = ccss_pkg::STAT_BAD_NAME;
                ccss_pkg::PH_NAME:
                    if (is_name_body(c))
                        r.role = ccss_pkg::ROLE_NAME;
                    else if (is_blank_byte(c))
                    begin
                        sc_phase = ccss_pkg::PH_GAP;
                        r.role   = ccss_pkg::ROLE_SPACE;
                    end
                    else if (c == ccss_pkg::CH_LPAREN)
                    begin
                        sc_phase = ccss_pkg::PH_LIST;
                        r.role   = ccss_pkg::ROLE_OPEN;
                    end
                    else
                        sc_err = ccss_pkg::STAT_JUNK;
                ccss_pkg::PH_GAP:
                    if (is_blank_byte(c))
                        r.role = ccss_pkg::ROLE_SPACE;
                    else if (c == ccss_pkg::CH_LPAREN)
                    begin
                        sc_phase = ccss_pkg::PH_LIST;
                        r.role   = ccss_pkg::ROLE_OPEN;
                    end
                    else
                        sc_err = ccss_pkg::STAT_JUNK;
                ccss_pkg::PH_LIST:
                begin
                    r.arg_number = sc_args[3:0];
                    r.role       = ccss_pkg::ROLE_ARG;
                    if (c == ccss_pkg::CH_BSLASH && !sc_esc && quoted)
                    begin
                        sc_esc  = 1'b1;
                        clr_esc = 1'b0;
                    end
                    else if (c == ccss_pkg::CH_SQUOTE)
                    begin
                        if (!sc_dq && (!sc_sq || !sc_esc))
                            sc_sq = !sc_sq;
                    end
                    else if (c == ccss_pkg::CH_DQUOTE)
                    begin
                        if (!sc_sq && (!sc_dq || !sc_esc))
                            sc_dq = !sc_dq;
                    end
                    else if (c == ccss_pkg::CH_LPAREN && !quoted)
                    begin
                        sc_nest++;
                        if (sc_nest > MAX_NEST)
                        begin
                            r.role       = ccss_pkg::ROLE_IGNORED;
                            r.arg_number = 4'd0;
                            sc_err       = ccss_pkg::STAT_UNMATCHED;
                            clr_esc      = 1'b0;
                        end
                    end
                    else if (c == ccss_pkg::CH_COMMA && !quoted && sc_nest == 0)
                    begin
                        clr_esc = 1'b0;
                        if (sc_args + 1 >= MAX_ARGS)
                        begin
                            r.role       = ccss_pkg::ROLE_IGNORED;
                            r.arg_number = 4'd0;
                            sc_err       = ccss_pkg::STAT_TOO_MANY;
                        end
                        else
                        begin
                            sc_args++;
                            r.role = ccss_pkg::ROLE_COMMA;
                        end
                    end
                    else if (c == ccss_pkg::CH_RPAREN && !quoted)
                    begin
                        if (sc_nest != 0)
                            sc_nest--;
                        else
                        begin
                            sc_phase = ccss_pkg::PH_TRAIL;
                            r.role   = ccss_pkg::ROLE_CLOSE;
                            clr_esc  = 1'b0;
                        end
                    end
                    if (clr_esc)
                        sc_esc = 1'b0;
                end
                default:
                    if (is_blank_byte(c))
                        r.role = ccss_pkg::ROLE_SPACE;
                    else
                        sc_err = ccss_pkg::STAT_JUNK;
            endcase
        end
        if (fin)
        begin
            if (sc_err != ccss_pkg::STAT_OK)
                r.status = sc_err;
            else if (sc_phase == ccss_pkg::PH_LEAD)
                r.status = ccss_pkg::STAT_BAD_NAME;
            else if (sc_phase == ccss_pkg::PH_LIST)
            begin
                if (sc_sq)
                    r.status = ccss_pkg::STAT_OPEN_SQ;
                else if (sc_dq)
                    r.status = ccss_pkg::STAT_OPEN_DQ;
                else if (sc_nest != 0)
                    r.status = ccss_pkg::STAT_UNMATCHED;
                else if (sc_esc)
                    r.status = ccss_pkg::STAT_DANGLE_ESC;
                else
                    r.status = ccss_pkg::STAT_UNCLOSED;
            end
            else
                r.status = ccss_pkg::STAT_OK;
            scan_clear();
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_blank();
        logic [7:0] blanks[7] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0A, 8'h0D, 8'h00};
        return blanks[$urandom_range(0, 6)];
    endfunction

    function automatic logic [7:0] rand_head();
        int unsigned r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'h61 + r[7:0];
        else if (r < 52)
            return 8'h41 + r[7:0] - 8'd26;
        return "_";
    endfunction

    function automatic logic [7:0] rand_body();
        int unsigned r;
        r = $urandom_range(0, 62);
        if (r < 10)
            return 8'h30 + r[7:0];
        return rand_head();
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (c == ccss_pkg::CH_SQUOTE || c == ccss_pkg::CH_DQUOTE ||
               c == ccss_pkg::CH_LPAREN || c == ccss_pkg::CH_RPAREN ||
               c == ccss_pkg::CH_COMMA || c == ccss_pkg::CH_BSLASH)
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    task automatic put(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.insert(line_buf.size(), s[i]);
    endtask

    task automatic gen_quoted(input logic [7:0] q);
        logic [7:0] c;
        put(q);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 3))
                0: put(rand_body());
                1:
                begin
                    put(ccss_pkg::CH_BSLASH);
                    put(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    put(ccss_pkg::CH_BSLASH);
                    put(q);
                end
                default:
                begin
                    c = 8'($urandom_range(0, 255));
                    put((c == q || c == ccss_pkg::CH_BSLASH) ? rand_body() : c);
                end
            endcase
        end
        put(q);
    endtask

    task automatic gen_arg(input int depth);
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 5))
                0: put(rand_body());
                1: put(rand_blank());
                2: gen_quoted(ccss_pkg::CH_SQUOTE);
                3: gen_quoted(ccss_pkg::CH_DQUOTE);
                4:
                    if (depth < 2)
                    begin
                        put(ccss_pkg::CH_LPAREN);
                        gen_arg(depth + 1);
                        if ($urandom_range(0, 1) != 0)
                        begin
                            put(ccss_pkg::CH_COMMA);
                            gen_arg(depth + 1);
                        end
                        put(ccss_pkg::CH_RPAREN);
                    end
                default: put(rand_plain());
            endcase
        end
    endtask

    task automatic gen_call(input int nargs);
        repeat ($urandom_range(0, 2))
            put(rand_blank());
        put(rand_head());
        repeat ($urandom_range(0, 5))
            put(rand_body());
        repeat ($urandom_range(0, 2))
            put(rand_blank());
        put(ccss_pkg::CH_LPAREN);
        for (int i = 0; i < nargs; i++)
        begin
            if (i > 0)
                put(ccss_pkg::CH_COMMA);
            gen_arg(0);
        end
        put(ccss_pkg::CH_RPAREN);
        repeat ($urandom_range(0, 2))
            put(rand_blank());
    endtask

    task automatic mutate();
        int unsigned pos;
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 2))
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1:
                while (line_buf.size() > pos + 1)
                    void'(line_buf.pop_back());
            default: line_buf.insert(pos, 8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic flush_line();
        foreach (line_buf[i])
            pending_words.insert(pending_words.size(),
                                 word_t'{ch: line_buf[i], fin: (i == line_buf.size() - 1)});
        line_buf.delete();
    endtask

    task automatic check_field(input string field, input logic [3:0] want, input logic [3:0] got);
        if (want !== got)
        begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s mismatch on tag %0d, expected %0d, got %0d",
                         $time, field, tags_checked, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            scan_clear();
        end
        else
        begin
            if (in_valid && in_ready)
                expected_tags.insert(expected_tags.size(), scan_byte(in_byte, last));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= w.ch;
                    last     <= w.fin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        ccss_pkg::scan_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: unexpected tag, expected none, got role %0d status %0d",
                                 $time, role, status);
                    err_count++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("role", {1'b0, want.role}, {1'b0, role});
                    check_field("arg_number", want.arg_number, arg_number);
                    check_field("end_of_command", {3'b0, want.end_of_command},
                                {3'b0, end_of_command});
                    check_field("status", want.status, status);
                    tags_checked++;
                    if (want.end_of_command)
                    begin
                        lines_checked++;
                        status_seen[want.status] = 1'b1;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin
        bit          deep_done;
        int unsigned kind;
        deep_done = 1'b0;

        put(8'h00);
        flush_line();
        put_str("9");
        flush_line();
        put_str("a+");
        flush_line();
        put_str("b (");
        flush_line();
        put_str("c()");
        flush_line();
        put_str("x('\\'',\"(\")");
        flush_line();
        put_str("A(\"");
        flush_line();

        while (pending_words.size() < DIRECTED + RAND_WORDS)
        begin
            kind = $urandom_range(0, 99);
            if (!deep_done && pending_words.size() > RAND_WORDS / 2)
            begin
                deep_done = 1'b1;
                put_str("n(");
                repeat (MAX_NEST + 1)
                    put(ccss_pkg::CH_LPAREN);
                put_str("z)");
            end
            else if (kind < 60)
            begin
                gen_call($urandom_range(0, 4));
                if ($urandom_range(0, 4) == 0)
                    mutate();
            end
            else if (kind < 70)
                gen_call($urandom_range(MAX_ARGS - 2, MAX_ARGS + 1));
            else if (kind < 85)
            begin
                gen_call($urandom_range(1, 3));
                while (line_buf.size() > 1 && $urandom_range(0, 3) != 0)
                    void'(line_buf.pop_back());
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    put(8'($urandom_range(0, 255)));
            end
            flush_line();
        end

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (!((pending_words.size() == 0 && !in_valid && expected_tags.size() == 0) ||
                 stall_cycles >= STALL_LIMIT))
            @(negedge clk);

        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d tags still owed",
                     $time, STALL_LIMIT, expected_tags.size());
            $display("DONE: errors detected");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            $display("Scanned %0d command lines, %0d byte tags compared, %0d mismatches",
                     lines_checked, tags_checked, err_count);
            $display("End status codes reached, one bit per code from 0: %b", status_seen[8:0]);
            if (err_count == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/ccss_pkg.sv
src/ccss_step.sv
src/command_call_syntax_scanner_top.sv
dv/testbench.sv
